/* rtl/arp_pkg.sv */
`default_nettype none

package arp_pkg;

  // Storage limits of the info line buffer.
  localparam int unsigned MAX_LINES = 16;
  localparam int unsigned LINE_LEN  = 128;

  // Internal counter widths follow the limits.
  localparam int unsigned LC_W = $clog2(MAX_LINES + 1);
  localparam int unsigned CI_W = $clog2(LINE_LEN);

  // Fixed field widths of the channels.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LDONE_W  = 5;
  localparam int unsigned WLINE_W  = 4;
  localparam int unsigned WPOS_W   = 7;

  // Characters of the response grammar.
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;
  localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
  localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'd0,
    ST_LF1     = 5'd1,
    ST_FIRST   = 5'd2,
    ST_OK_K    = 5'd3,
    ST_OK_CR   = 5'd4,
    ST_OK_LF   = 5'd5,
    ST_E_R1    = 5'd6,
    ST_E_R2    = 5'd7,
    ST_E_O     = 5'd8,
    ST_E_R3    = 5'd9,
    ST_E_CR    = 5'd10,
    ST_E_LF    = 5'd11,
    ST_INFO    = 5'd12,
    ST_INFO_LF = 5'd13,
    ST_AFTER   = 5'd14,
    ST_FIN_LF  = 5'd15,
    ST_FINAL   = 5'd16
  } parse_state_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_BUSY = 2'd0,
    STAT_DONE = 2'd1,
    STAT_ERR  = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic                final_ok;
    logic [LDONE_W-1:0]  lines_done;
    logic                char_write;
    logic                line_end;
    logic [WLINE_W-1:0]  write_line;
    logic [WPOS_W-1:0]   write_pos;
    logic [BYTE_W-1:0]   write_char;
  } result_t;

endpackage

`default_nettype wire

/* rtl/arp_if.sv */
`default_nettype none

// Received byte channel.
interface arp_rx_if;
  import arp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Per-byte parse result channel.
interface arp_res_if;
  import arp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                final_ok;
  logic [LDONE_W-1:0]  lines_done;
  logic                char_write;
  logic                line_end;
  logic [WLINE_W-1:0]  write_line;
  logic [WPOS_W-1:0]   write_pos;
  logic [BYTE_W-1:0]   write_char;

  modport source (
    output valid, input ready,
    output status, output final_ok, output lines_done, output char_write,
    output line_end, output write_line, output write_pos, output write_char
  );
  modport sink (
    input valid, output ready,
    input status, input final_ok, input lines_done, input char_write,
    input line_end, input write_line, input write_pos, input write_char
  );
endinterface

`default_nettype wire

/* rtl/at_response_parser_top.sv */
// AT modem response parser.
// rx_i (valid/ready) carries one received modem byte per transaction. res_o
// (valid/ready) returns exactly one result transaction per byte: status
// (busy, done, syntax error), the OK/ERROR verdict, the info line count and
// a store write (character or line terminator with line index and position).
// An accepted byte first enters the input register, then the parse logic updates
// the state and loads the result register, which drives res_o. Throughput is
// one byte per cycle while res_o does not stall.
// When res_o stalls, the result register holds and the input register holds
// one more byte; rx_i.ready drops only while both are full, so no transaction
// is lost or repeated.
// Reset clears the valid flags, the parse state, the line count and the
// character index; the parser then waits for the opening CR and ignores noise.
// After a complete response or a syntax error the parser returns to idle.
`default_nettype none

module at_response_parser_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  arp_rx_if.sink      rx_i,
  arp_res_if.source   res_o
);
  import arp_pkg::*;

  // Input stage.
  logic              in_vld_q, in_vld_d;
  logic [BYTE_W-1:0] in_byte_q;

  // Parse state.
  parse_state_e      state_q, state_d;
  logic [LC_W-1:0]   line_q, line_d;
  logic [CI_W-1:0]   idx_q, idx_d;

  // Result stage.
  logic              out_vld_q, out_vld_d;
  result_t           res_q, res_d;

  logic              advance;
  logic              in_fire;
  logic              parse_fire;

  // Move the pipe whenever the result slot is free or being emptied.
  assign advance    = !out_vld_q || res_o.ready;
  assign rx_i.ready = !in_vld_q || advance;
  assign in_fire    = rx_i.valid && rx_i.ready;
  assign parse_fire = in_vld_q && advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = advance ? in_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: load only on a handshake, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (parse_fire) begin
      res_q <= res_d;
    end
  end

  // Parse state register; it advances once per byte leaving the input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      line_q  <= '0;
      idx_q   <= '0;
    end else if (parse_fire) begin
      state_q <= state_d;
      line_q  <= line_d;
      idx_q   <= idx_d;
    end
  end

  // Next state and the result of the byte in the input register.
  always_comb begin
    logic              err;
    logic              done;
    logic              printable;
    logic              line_room;
    logic              char_room;
    logic [BYTE_W-1:0] c;

    c         = in_byte_q;
    err       = 1'b0;
    done      = 1'b0;
    printable = (c >= CH_SPACE) && (c <= CH_TILDE);
    line_room = line_q < LC_W'(MAX_LINES);
    char_room = idx_q < CI_W'(LINE_LEN - 1);

    state_d = state_q;
    line_d  = line_q;
    idx_d   = idx_q;

    res_d            = '0;
    res_d.status     = STAT_BUSY;

    unique case (state_q)
      ST_LF1: begin
        if (c == CH_LF) state_d = ST_FIRST; else err = 1'b1;
      end
      ST_FIRST: begin
        if (c == CH_O) begin
          state_d = ST_OK_K;
        end else if (c == CH_E) begin
          state_d = ST_E_R1;
        end else if (c == CH_PLUS) begin
          state_d = ST_INFO;
        end else begin
          err = 1'b1;
        end
      end
      ST_OK_K: begin
        if (c == CH_K) state_d = ST_OK_CR; else err = 1'b1;
      end
      ST_OK_CR: begin
        if (c == CH_CR) state_d = ST_OK_LF; else err = 1'b1;
      end
      ST_OK_LF: begin
        if (c == CH_LF) begin
          done           = 1'b1;
          res_d.final_ok = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      ST_E_R1: begin
        if (c == CH_R) state_d = ST_E_R2; else err = 1'b1;
      end
      ST_E_R2: begin
        if (c == CH_R) state_d = ST_E_O; else err = 1'b1;
      end
      ST_E_O: begin
        if (c == CH_O) state_d = ST_E_R3; else err = 1'b1;
      end
      ST_E_R3: begin
        if (c == CH_R) state_d = ST_E_CR; else err = 1'b1;
      end
      ST_E_CR: begin
        if (c == CH_CR) state_d = ST_E_LF; else err = 1'b1;
      end
      ST_E_LF: begin
        if (c == CH_LF) done = 1'b1; else err = 1'b1;
      end
      ST_INFO: begin
        if (printable) begin
          // Drop characters past the line limit or from the last position of the line on.
          if (line_room && char_room) begin
            res_d.char_write = 1'b1;
            res_d.write_line = WLINE_W'(line_q);
            res_d.write_pos  = WPOS_W'(idx_q);
            res_d.write_char = c;
            idx_d            = idx_q + 1'b1;
          end
        end else if (c == CH_CR) begin
          if (line_room) begin
            res_d.line_end   = 1'b1;
            res_d.write_line = WLINE_W'(line_q);
            res_d.write_pos  = WPOS_W'(idx_q);
            idx_d            = '0;
            line_d           = line_q + 1'b1;
          end
          state_d = ST_INFO_LF;
        end else begin
          err = 1'b1;
        end
      end
      ST_INFO_LF: begin
        if (c == CH_LF) state_d = ST_AFTER; else err = 1'b1;
      end
      ST_AFTER: begin
        if (c == CH_PLUS) begin
          state_d = ST_INFO;
        end else if (c == CH_CR) begin
          state_d = ST_FIN_LF;
        end else begin
          err = 1'b1;
        end
      end
      ST_FIN_LF: begin
        if (c == CH_LF) state_d = ST_FINAL; else err = 1'b1;
      end
      ST_FINAL: begin
        if (c == CH_O) begin
          state_d = ST_OK_K;
        end else if (c == CH_E) begin
          state_d = ST_E_R1;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        // Idle and unused codes: wait for the opening CR, ignore noise.
        state_d = (c == CH_CR) ? ST_LF1 : ST_IDLE;
      end
    endcase

    if (err) begin
      res_d.status = STAT_ERR;
    end else if (done) begin
      res_d.status = STAT_DONE;
    end

    // Report the count including a line completed by this byte.
    res_d.lines_done = LDONE_W'(line_d);

    // Return to idle after a verdict or a syntax error.
    if (err || done) begin
      state_d = ST_IDLE;
      line_d  = '0;
      idx_d   = '0;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.status     = res_q.status;
  assign res_o.final_ok   = res_q.final_ok;
  assign res_o.lines_done = res_q.lines_done;
  assign res_o.char_write = res_q.char_write;
  assign res_o.line_end   = res_q.line_end;
  assign res_o.write_line = res_q.write_line;
  assign res_o.write_pos  = res_q.write_pos;
  assign res_o.write_char = res_q.write_char;

`ifndef SYNTH
  // A verdict or a syntax error leaves the parser idle with cleared counters.
  a_idle_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_fire && (res_d.status != STAT_BUSY) |=>
      (state_q == ST_IDLE) && (line_q == '0) && (idx_q == '0))
    else $error("parser not idle after end of response");

  // The stored line count never passes the line limit.
  a_line_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q <= LC_W'(MAX_LINES))
    else $error("line count beyond limit");

  // A store write only comes with a busy status, and a terminator carries no character.
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.char_write || res_q.line_end) |->
      (res_q.status == STAT_BUSY) && !(res_q.char_write && res_q.line_end))
    else $error("store write with wrong status");

  // A stalled result keeps the byte behind it in the input register.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_byte_q) && $stable(state_q))
    else $error("input stage lost a byte under stall");
`endif

endmodule

`default_nettype wire

/* sim/at_response_parser_top_tb.sv */
module at_response_parser_top_tb;
  import arp_pkg::*;

  // One row of the directed stimulus. Where typed is set, the result is
  // written down in the row (status, verdict and line count; every store
  // field zero). Otherwise the result comes from the parse predictor.
  typedef struct {
    logic [BYTE_W-1:0]  rx_byte;
    bit                 typed;
    status_e            status;
    logic               final_ok;
    logic [LDONE_W-1:0] lines_done;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  arp_rx_if  rx_if ();
  arp_res_if res_if ();

  at_response_parser_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // Free-running clock, period 2.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Parser state mirrored on the bench side.
  parse_state_e ps_now     = ST_IDLE;
  int unsigned  info_lines = 0;
  int unsigned  char_pos   = 0;

  // Results still owed by the block, oldest first.
  result_t parse_results_q [$];
  int      mismatches = 0;

  // Set during a stretch of the random part: neither side idles then.
  bit steady = 1'b0;

  // Directed part: noise after reset, a broken opening, a bare OK, a bare
  // ERROR (terminated CR then LF), one info line with both printable
  // extremes, then a control byte inside the second line.
  dir_row_t dir_tab [27] = '{
    '{8'hFF,   1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_CR,   1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{8'h41,   1'b1, STAT_ERR,  1'b0, 5'd0},
    '{CH_CR,   1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_LF,   1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_O,    1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_K,    1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_CR,   1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_LF,   1'b1, STAT_DONE, 1'b1, 5'd0},
    '{CH_CR,   1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_LF,   1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_E,    1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_R,    1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_R,    1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_O,    1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_R,    1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_CR,   1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_LF,   1'b1, STAT_DONE, 1'b0, 5'd0},
    '{CH_CR,   1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_LF,   1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_PLUS, 1'b1, STAT_BUSY, 1'b0, 5'd0},
    '{CH_SPACE, 1'b0, STAT_BUSY, 1'b0, 5'd0},
    '{CH_TILDE, 1'b0, STAT_BUSY, 1'b0, 5'd0},
    '{CH_CR,   1'b0, STAT_BUSY, 1'b0, 5'd0},
    '{CH_LF,   1'b1, STAT_BUSY, 1'b0, 5'd1},
    '{CH_PLUS, 1'b1, STAT_BUSY, 1'b0, 5'd1},
    '{8'h7F,   1'b1, STAT_ERR,  1'b0, 5'd1}
  };

  // Advance the mirrored parser by one byte and return the result it causes.
  function automatic result_t parse_byte(input logic [BYTE_W-1:0] c);
    result_t r;
    bit      err;
    r   = '0;
    err = 1'b0;
    case (ps_now)
      ST_LF1:     if (c == CH_LF) ps_now = ST_FIRST; else err = 1'b1;
      ST_FIRST: begin
        if (c == CH_O) ps_now = ST_OK_K;
        else if (c == CH_E) ps_now = ST_E_R1;
        else if (c == CH_PLUS) ps_now = ST_INFO;
        else err = 1'b1;
      end
      ST_OK_K:    if (c == CH_K) ps_now = ST_OK_CR; else err = 1'b1;
      ST_OK_CR:   if (c == CH_CR) ps_now = ST_OK_LF; else err = 1'b1;
      ST_OK_LF: begin
        if (c == CH_LF) begin
          r.status   = STAT_DONE;
          r.final_ok = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      ST_E_R1:    if (c == CH_R) ps_now = ST_E_R2; else err = 1'b1;
      ST_E_R2:    if (c == CH_R) ps_now = ST_E_O; else err = 1'b1;
      ST_E_O:     if (c == CH_O) ps_now = ST_E_R3; else err = 1'b1;
      ST_E_R3:    if (c == CH_R) ps_now = ST_E_CR; else err = 1'b1;
      ST_E_CR:    if (c == CH_CR) ps_now = ST_E_LF; else err = 1'b1;
      ST_E_LF: begin
        if (c == CH_LF) r.status = STAT_DONE;
        else err = 1'b1;
      end
      ST_INFO: begin
        if (c >= CH_SPACE && c <= CH_TILDE) begin
          // Store only below the line limit and before the last position.
          if (info_lines < MAX_LINES && char_pos < LINE_LEN - 1) begin
            r.char_write = 1'b1;
            r.write_line = WLINE_W'(info_lines);
            r.write_pos  = WPOS_W'(char_pos);
            r.write_char = c;
            char_pos++;
          end
        end else if (c == CH_CR) begin
          if (info_lines < MAX_LINES) begin
            r.line_end   = 1'b1;
            r.write_line = WLINE_W'(info_lines);
            r.write_pos  = WPOS_W'(char_pos);
            char_pos     = 0;
            info_lines++;
          end
          ps_now = ST_INFO_LF;
        end else begin
          err = 1'b1;
        end
      end
      ST_INFO_LF: if (c == CH_LF) ps_now = ST_AFTER; else err = 1'b1;
      ST_AFTER: begin
        if (c == CH_PLUS) ps_now = ST_INFO;
        else if (c == CH_CR) ps_now = ST_FIN_LF;
        else err = 1'b1;
      end
      ST_FIN_LF:  if (c == CH_LF) ps_now = ST_FINAL; else err = 1'b1;
      ST_FINAL: begin
        if (c == CH_O) ps_now = ST_OK_K;
        else if (c == CH_E) ps_now = ST_E_R1;
        else err = 1'b1;
      end
      // Idle and unused codes: wait for the opening CR, ignore the rest.
      default:    ps_now = (c == CH_CR) ? ST_LF1 : ST_IDLE;
    endcase
    if (err) r.status = STAT_ERR;
    r.lines_done = LDONE_W'(info_lines);
    // Drop back to idle once the response is finished either way.
    if (r.status != STAT_BUSY) begin
      ps_now     = ST_IDLE;
      info_lines = 0;
      char_pos   = 0;
    end
    return r;
  endfunction

  // Offer one byte on rx, starting at a falling edge, and hold it until the
  // block takes it. Return at the falling edge after the transaction.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
                           input result_t typed_res);
    result_t pred;
    while (!steady && $urandom_range(0, 99) < 23) begin
      rx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    pred = parse_byte(b);
    parse_results_q.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: stall at random, except in the steady stretch.
  always @(negedge clk_i) begin
    res_if.ready <= rst_ni && (steady || $urandom_range(0, 99) >= 23);
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (parse_results_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d", $time,
                 res_if.status);
        mismatches++;
      end else begin
        want = parse_results_q.pop_front();
        check_field("status",     want.status,     res_if.status);
        check_field("final_ok",   want.final_ok,   res_if.final_ok);
        check_field("lines_done", want.lines_done, res_if.lines_done);
        check_field("char_write", want.char_write, res_if.char_write);
        check_field("line_end",   want.line_end,   res_if.line_end);
        check_field("write_line", want.write_line, res_if.write_line);
        check_field("write_pos",  want.write_pos,  res_if.write_pos);
        check_field("write_char", want.write_char, res_if.write_char);
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] resp_q [$];
    logic [BYTE_W-1:0] b;
    result_t           typed_res;
    int unsigned       rand_items;
    int unsigned       nlines;
    int unsigned       nchars;
    int unsigned       cut;

    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table.
    foreach (dir_tab[i]) begin
      typed_res            = '0;
      typed_res.status     = dir_tab[i].status;
      typed_res.final_ok   = dir_tab[i].final_ok;
      typed_res.lines_done = dir_tab[i].lines_done;
      send_byte(dir_tab[i].rx_byte, dir_tab[i].typed, typed_res);
    end

    // Random part: mostly well-formed responses with random content, some
    // with a byte replaced or cut short, separated by idle noise.
    typed_res  = '0;
    rand_items = 0;
    while (rand_items < 750) begin
      steady = (rand_items >= 300 && rand_items < 450);

      // Idle noise ahead of the response; keep CR out so the response
      // starts where it is meant to.
      repeat ($urandom_range(0, 2)) begin
        b = BYTE_W'($urandom);
        if (b == CH_CR) b = 8'h00;
        send_byte(b, 1'b0, typed_res);
      end

      resp_q.delete();
      resp_q.push_back(CH_CR);
      resp_q.push_back(CH_LF);
      // Now and then run past the line limit.
      nlines = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 3);
      repeat (nlines) begin
        resp_q.push_back(CH_PLUS);
        // Rarely fill the line up to and past its length.
        nchars = ($urandom_range(0, 19) == 0) ? $urandom_range(126, 130)
                                              : $urandom_range(0, 8);
        repeat (nchars) resp_q.push_back(BYTE_W'($urandom_range(CH_SPACE, CH_TILDE)));
        resp_q.push_back(CH_CR);
        resp_q.push_back(CH_LF);
      end
      if (nlines > 0) begin
        resp_q.push_back(CH_CR);
        resp_q.push_back(CH_LF);
      end
      if ($urandom_range(0, 1)) begin
        resp_q.push_back(CH_O);
        resp_q.push_back(CH_K);
      end else begin
        resp_q.push_back(CH_E);
        resp_q.push_back(CH_R);
        resp_q.push_back(CH_R);
        resp_q.push_back(CH_O);
        resp_q.push_back(CH_R);
      end
      resp_q.push_back(CH_CR);
      resp_q.push_back(CH_LF);

      // Break some responses: replace one byte, or cut the tail off.
      if ($urandom_range(0, 5) == 0)
        resp_q[$urandom_range(0, resp_q.size() - 1)] = BYTE_W'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, resp_q.size() - 1);
        while (resp_q.size() > cut) void'(resp_q.pop_back());
      end

      foreach (resp_q[i]) send_byte(resp_q[i], 1'b0, typed_res);
      rand_items += resp_q.size();
    end
    steady = 1'b0;
    rx_if.valid <= 1'b0;

    // Drain: wait for every owed result, then keep watching for anything extra.
    while (parse_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/arp_pkg.sv
rtl/arp_if.sv
rtl/at_response_parser_top.sv
sim/at_response_parser_top_tb.sv
